/* sv/button_tag_event_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for button_tag_event_unit
// Immediate-consequence and next-cycle checks, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef BUTTON_TAG_EVENT_UNIT_ASSERT_SVH
`define BUTTON_TAG_EVENT_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BTUE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BTUE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BTUE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BTUE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* sv/btue_pkg.sv */
// ----------------------------------------------------------------------------
// btue_pkg
// Shared types and constants of the button and tag event unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btue_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;

   localparam int TIME_W     = 32;
   localparam int UID_W      = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int LEVEL_W    = 4;
   localparam int DROP_W     = 2;

   localparam logic [15:0] DEBOUNCE_RST    = 16'd20;
   localparam logic [15:0] SCAN_PERIOD_RST = 16'd750;
   localparam logic [3:0]  MISS_LIMIT_RST  = 4'd2;
   localparam logic [3:0]  MISS_MAX        = 4'd15;

   localparam logic FUNC_PUMP = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [1:0] SCAN_NONE = 2'd1;
   localparam logic [1:0] SCAN_TAG  = 2'd2;

   typedef enum logic [1:0] {
      EV_DOWN = 2'd0,
      EV_UP   = 2'd1,
      EV_TAG  = 2'd2,
      EV_GONE = 2'd3
   } ev_kind_type;

   typedef enum logic [1:0] {
      REG_RFID_ON     = 2'd0,
      REG_DEBOUNCE    = 2'd1,
      REG_SCAN_PERIOD = 2'd2,
      REG_MISS_LIMIT  = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic               btn_valid;
      ev_kind_type        btn_kind;
      logic               tag_valid;
      ev_kind_type        tag_kind;
      logic [UID_W-1:0]   tag_uid;
   } ev_post_type;

endpackage

`default_nettype wire

/* sv/btue_chan_if.sv */
// ----------------------------------------------------------------------------
// btue request and response channels
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface btue_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [btue_pkg::TIME_W-1:0]   now_ms;
   logic                          button_raw;
   logic                          allow_scan;
   logic [1:0]                    scan_status;
   logic [btue_pkg::UID_W-1:0]    scan_uid;

   modport source (output valid, func, now_ms, button_raw, allow_scan, scan_status,
                   scan_uid, input ready);
   modport sink   (input valid, func, now_ms, button_raw, allow_scan, scan_status,
                   scan_uid, output ready);
endinterface

interface btue_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           event_valid;
   logic [1:0]                     event_type;
   logic [btue_pkg::UID_W-1:0]     event_uid;
   logic                           scan_used;
   logic [btue_pkg::DROP_W-1:0]    drop_count;
   logic [btue_pkg::LEVEL_W-1:0]   queue_level;

   modport source (output valid, event_valid, event_type, event_uid, scan_used,
                   drop_count, queue_level, input ready);
   modport sink   (input valid, event_valid, event_type, event_uid, scan_used,
                   drop_count, queue_level, output ready);
endinterface

`default_nettype wire

/* sv/button_tag_event_unit.sv */
// ----------------------------------------------------------------------------
// button_tag_event_unit
// Debounced button and tag-presence events, queued in a RAM-based FIFO.
// ----------------------------------------------------------------------------
// req_if carries pump items (func 0: time, raw button, scan result) and pop
// items (func 1). Every item yields exactly one rsp_if item. A pump reports
// scan use, drops and queue level; a pop returns the oldest queued event.
// csr_we/csr_index/csr_wdata write the four configuration registers.
// A response passes the queue RAM read, then the output register, from req
// accept to rsp valid. Throughput: one item per cycle while nothing stalls;
// a pump posting both a button and a tag event holds off the next item, as
// the queue RAM's one write port takes the second event the following cycle.
// When rsp_if.ready is low the output register and the stage behind it hold,
// so up to two items are absorbed before req_if.ready drops.
// Reset (synchronous) empties the queue and restores register defaults; the
// queue RAM needs no clearing pass, as only written entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_tag_event_unit #(
   parameter int QUEUE_DEPTH = btue_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   btue_req_if.sink                              req_if,
   btue_rsp_if.source                            rsp_if,
   input  wire logic                             csr_we,
   input  wire logic [btue_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [btue_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import btue_pkg::*;

`include "button_tag_event_unit_assert.svh"

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = AW + 1;
   localparam int EW = 2 + UID_W;

   typedef struct packed {
      logic               hit;
      logic               used;
      logic [DROP_W-1:0]  drop;
      logic [LEVEL_W-1:0] level;
   } s1_type;

   logic              accept, pump_go, pop_go;
   ev_post_type       post;
   logic              scan_used;

   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              pend_ff;
   logic [AW-1:0]     pend_addr_ff;
   logic [EW-1:0]     pend_data_ff;

   logic              s1_valid_ff;
   s1_type            s1_ff, s1_in;
   logic              s1_move;
   logic [EW-1:0]     ram_q;

   logic              out_valid_ff;
   logic              out_hit_ff;
   logic [1:0]        out_kind_ff;
   logic [UID_W-1:0]  out_uid_ff;
   logic              out_used_ff;
   logic [DROP_W-1:0] out_drop_ff;
   logic [LEVEL_W-1:0] out_level_ff;

   logic [1:0]        ev_count;
   logic              posted0, posted1;
   logic [1:0]        posted_count;
   logic [SW-1:0]     slot_sum0, slot_sum1, rd_sum;
   logic [AW-1:0]     waddr0, waddr1;
   logic [EW-1:0]     wdata0, wdata1;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [EW-1:0]     wr_data;

   assign s1_move     = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !pend_ff && (!s1_valid_ff || s1_move);
   assign accept      = req_if.valid && req_if.ready;
   assign pump_go     = accept && (req_if.func == FUNC_PUMP);
   assign pop_go      = accept && (req_if.func == FUNC_POP);

   btue_sense u_sense (
      .clock       (clock),
      .reset       (reset),
      .pump_go     (pump_go),
      .now_ms      (req_if.now_ms),
      .button_raw  (req_if.button_raw),
      .allow_scan  (req_if.allow_scan),
      .scan_status (req_if.scan_status),
      .scan_uid    (req_if.scan_uid),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .post        (post),
      .scan_used   (scan_used)
   );

   // tail slot and the one after it, wrapped at the queue depth
   assign slot_sum0 = SW'(rd_ptr_ff) + SW'(fill_ff);
   assign waddr0    = (slot_sum0 >= SW'(QUEUE_DEPTH)) ? AW'(slot_sum0 - SW'(QUEUE_DEPTH))
                                                      : AW'(slot_sum0);
   assign slot_sum1 = SW'(waddr0) + SW'(1);
   assign waddr1    = (slot_sum1 >= SW'(QUEUE_DEPTH)) ? AW'(slot_sum1 - SW'(QUEUE_DEPTH))
                                                      : AW'(slot_sum1);
   assign rd_sum    = SW'(rd_ptr_ff) + SW'(1);

   assign ev_count = {1'b0, post.btn_valid} + {1'b0, post.tag_valid};
   assign posted0  = pump_go && (ev_count != 2'd0) && (fill_ff < FW'(QUEUE_DEPTH));
   assign posted1  = pump_go && (ev_count == 2'd2) && (fill_ff < FW'(QUEUE_DEPTH - 1));
   assign posted_count = {1'b0, posted0} + {1'b0, posted1};

   assign wdata0 = post.btn_valid ? {post.btn_kind, {UID_W{1'b0}}}
                                  : {post.tag_kind, post.tag_uid};
   assign wdata1 = {post.tag_kind, post.tag_uid};

   assign wr_en   = pend_ff || posted0;
   assign wr_addr = pend_ff ? pend_addr_ff : waddr0;
   assign wr_data = pend_ff ? pend_data_ff : wdata0;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      s1_in     = '0;
      if (pump_go) begin
         fill_in  = fill_ff + FW'(posted_count);
         s1_in.used = scan_used;
         s1_in.drop = ev_count - posted_count;
      end else if (pop_go && fill_ff != '0) begin
         rd_ptr_in = (rd_sum >= SW'(QUEUE_DEPTH)) ? AW'(rd_sum - SW'(QUEUE_DEPTH))
                                                  : AW'(rd_sum);
         fill_in   = fill_ff - FW'(1);
         s1_in.hit = 1'b1;
      end
      s1_in.level = LEVEL_W'(fill_in);
   end

   btue_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rd_ptr_ff <= rd_ptr_in;
            fill_ff   <= fill_in;
         end
         pend_ff <= posted1;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (posted1) begin
         pend_addr_ff <= waddr1;
         pend_data_ff <= wdata1;
      end
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         out_hit_ff   <= s1_ff.hit;
         out_kind_ff  <= s1_ff.hit ? ram_q[EW-1:UID_W] : 2'd0;
         out_uid_ff   <= s1_ff.hit ? ram_q[UID_W-1:0] : '0;
         out_used_ff  <= s1_ff.used;
         out_drop_ff  <= s1_ff.drop;
         out_level_ff <= s1_ff.level;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.event_valid = out_hit_ff;
   assign rsp_if.event_type  = out_kind_ff;
   assign rsp_if.event_uid   = out_uid_ff;
   assign rsp_if.scan_used   = out_used_ff;
   assign rsp_if.drop_count  = out_drop_ff;
   assign rsp_if.queue_level = out_level_ff;

   `BTUE_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(QUEUE_DEPTH), "queue overfilled")
   `BTUE_ASSERT_IMP(a_pend_blocks, clock, reset, pend_ff, !req_if.ready, "accept during pending write")
   `BTUE_ASSERT_NXT(a_pend_once, clock, reset, pend_ff, !pend_ff, "pending write lasted two cycles")
   `BTUE_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_move, s1_valid_ff, "stage one lost an item")

endmodule

`default_nettype wire

/* sv/btue_ram.sv */
// ----------------------------------------------------------------------------
// btue_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btue_ram #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/btue_sense.sv */
// ----------------------------------------------------------------------------
// btue_sense
// Button debounce, tag presence tracking and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btue_sense (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                pump_go,
   input  wire logic [btue_pkg::TIME_W-1:0]         now_ms,
   input  wire logic                                button_raw,
   input  wire logic                                allow_scan,
   input  wire logic [1:0]                          scan_status,
   input  wire logic [btue_pkg::UID_W-1:0]          scan_uid,
   input  wire logic                                csr_we,
   input  wire logic [btue_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [btue_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output btue_pkg::ev_post_type                    post,
   output logic                                     scan_used
);
   import btue_pkg::*;

   logic              rfid_on_ff, rfid_on_in;
   logic [15:0]       debounce_ff, debounce_in;
   logic [15:0]       period_ff, period_in;
   logic [3:0]        limit_ff, limit_in;

   logic              stable_ff, stable_in;
   logic              prev_raw_ff, prev_raw_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              present_ff, present_in;
   logic [UID_W-1:0]  known_uid_ff, known_uid_in;
   logic [3:0]        miss_ff, miss_in;
   logic [TIME_W-1:0] last_scan_ff, last_scan_in;
   logic              armed_ff, armed_in;

   logic [TIME_W-1:0] btn_age;
   logic [TIME_W-1:0] scan_age;
   logic [3:0]        miss_next;
   logic              scan_due;

   assign btn_age  = now_ms - change_time_ff;
   assign scan_age = now_ms - last_scan_ff;
   assign scan_due = rfid_on_ff && allow_scan &&
                     (armed_ff || scan_age >= {16'd0, period_ff});
   assign miss_next = (miss_ff < MISS_MAX) ? miss_ff + 4'd1 : miss_ff;

   always_comb begin
      rfid_on_in     = rfid_on_ff;
      debounce_in    = debounce_ff;
      period_in      = period_ff;
      limit_in       = limit_ff;
      stable_in      = stable_ff;
      prev_raw_in    = prev_raw_ff;
      change_time_in = change_time_ff;
      present_in     = present_ff;
      known_uid_in   = known_uid_ff;
      miss_in        = miss_ff;
      last_scan_in   = last_scan_ff;
      armed_in       = armed_ff;
      post           = '0;
      post.btn_kind  = EV_UP;
      post.tag_kind  = EV_TAG;
      scan_used      = 1'b0;

      if (pump_go) begin
         if (button_raw != prev_raw_ff) begin
            prev_raw_in    = button_raw;
            change_time_in = now_ms;
         end else if (button_raw != stable_ff && btn_age >= {16'd0, debounce_ff}) begin
            stable_in      = button_raw;
            post.btn_valid = 1'b1;
            post.btn_kind  = button_raw ? EV_DOWN : EV_UP;
         end

         if (scan_due) begin
            scan_used    = 1'b1;
            armed_in     = 1'b0;
            last_scan_in = now_ms;
            case (scan_status)
               SCAN_NONE: begin
                  if (present_ff) begin
                     miss_in = miss_next;
                     if (miss_next >= limit_ff) begin
                        present_in     = 1'b0;
                        post.tag_valid = 1'b1;
                        post.tag_kind  = EV_GONE;
                     end
                  end
               end
               SCAN_TAG: begin
                  miss_in = 4'd0;
                  if (!present_ff || scan_uid != known_uid_ff) begin
                     present_in     = 1'b1;
                     known_uid_in   = scan_uid;
                     post.tag_valid = 1'b1;
                     post.tag_kind  = EV_TAG;
                     post.tag_uid   = scan_uid;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_RFID_ON: begin
               rfid_on_in = csr_wdata[0];
               present_in = 1'b0;
               miss_in    = 4'd0;
               armed_in   = 1'b1;
            end
            REG_DEBOUNCE:    debounce_in = csr_wdata;
            REG_SCAN_PERIOD: period_in   = csr_wdata;
            REG_MISS_LIMIT:  limit_in    = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rfid_on_ff     <= 1'b0;
         debounce_ff    <= DEBOUNCE_RST;
         period_ff      <= SCAN_PERIOD_RST;
         limit_ff       <= MISS_LIMIT_RST;
         stable_ff      <= 1'b0;
         prev_raw_ff    <= 1'b0;
         change_time_ff <= '0;
         present_ff     <= 1'b0;
         known_uid_ff   <= '0;
         miss_ff        <= 4'd0;
         last_scan_ff   <= '0;
         armed_ff       <= 1'b0;
      end else begin
         rfid_on_ff     <= rfid_on_in;
         debounce_ff    <= debounce_in;
         period_ff      <= period_in;
         limit_ff       <= limit_in;
         stable_ff      <= stable_in;
         prev_raw_ff    <= prev_raw_in;
         change_time_ff <= change_time_in;
         present_ff     <= present_in;
         known_uid_ff   <= known_uid_in;
         miss_ff        <= miss_in;
         last_scan_ff   <= last_scan_in;
         armed_ff       <= armed_in;
      end
   end

endmodule

`default_nettype wire
